// File: src/pec_pkg.sv
// ----------------------------------------------------------------------------
// pec_pkg
// shared widths, register indexes and curve codes of the easing curve block
// ----------------------------------------------------------------------------
package pec_pkg;

    localparam int TIME_WIDTH      = 16;
    localparam int FRAC_BITS       = 16;
    localparam int FUNC_WIDTH      = 4;
    localparam int VAL_WIDTH       = 24;

    // progress and curve values in unsigned q1.frac, range 0 .. one
    localparam int Q_WIDTH         = FRAC_BITS + 1;
    localparam int DIFF_WIDTH      = VAL_WIDTH + 1;
    localparam int PROD_WIDTH      = DIFF_WIDTH + Q_WIDTH + 1;
    localparam int SCALE_WIDTH     = PROD_WIDTH - FRAC_BITS;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = (TIME_WIDTH > VAL_WIDTH) ? TIME_WIDTH : VAL_WIDTH;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DURATION    = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_VALUE = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_END_VALUE   = 2'd2;

    localparam logic [FUNC_WIDTH-1:0] FUNC_QUAD_IN     = 4'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_QUAD_OUT    = 4'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_QUAD_INOUT  = 4'd2;
    localparam logic [FUNC_WIDTH-1:0] FUNC_CUBIC_IN    = 4'd3;
    localparam logic [FUNC_WIDTH-1:0] FUNC_CUBIC_OUT   = 4'd4;
    localparam logic [FUNC_WIDTH-1:0] FUNC_CUBIC_INOUT = 4'd5;
    localparam logic [FUNC_WIDTH-1:0] FUNC_QUART_IN    = 4'd6;
    localparam logic [FUNC_WIDTH-1:0] FUNC_QUART_OUT   = 4'd7;
    localparam logic [FUNC_WIDTH-1:0] FUNC_QUART_INOUT = 4'd8;

    localparam logic [Q_WIDTH-1:0] Q_ONE  = Q_WIDTH'(1) << FRAC_BITS;
    localparam logic [Q_WIDTH-1:0] Q_HALF = Q_WIDTH'(1) << (FRAC_BITS - 1);

    localparam logic signed [PROD_WIDTH-1:0]  ROUND_HALF = PROD_WIDTH'(1) << (FRAC_BITS - 1);
    localparam logic signed [SCALE_WIDTH-1:0] VAL_MAX    =
        SCALE_WIDTH'((64'sd1 <<< (VAL_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SCALE_WIDTH-1:0] VAL_MIN    =
        SCALE_WIDTH'(-(64'sd1 <<< (VAL_WIDTH - 1)));

    typedef enum logic [1:0] {
        KIND_IN,
        KIND_OUT,
        KIND_INOUT,
        KIND_NONE
    } curve_kind_t;

    typedef enum logic [1:0] {
        ORDER_2,
        ORDER_3,
        ORDER_4
    } curve_order_t;

    typedef struct packed {
        curve_kind_t  kind;
        curve_order_t order;
    } curve_sel_t;

endpackage

// File: src/pec_intf.sv
// ----------------------------------------------------------------------------
// pec_req_if / pec_rsp_if
// valid/ready channels carrying request and result words of the easing block
// ----------------------------------------------------------------------------
interface pec_req_if import pec_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FUNC_WIDTH-1:0] func;
    logic [TIME_WIDTH-1:0] elapsed;

    modport source (output valid, func, elapsed, input ready);
    modport sink   (input valid, func, elapsed, output ready);
endinterface

interface pec_rsp_if import pec_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [VAL_WIDTH-1:0] eased_value;
    logic                        time_clamped;

    modport source (output valid, eased_value, time_clamped, input ready);
    modport sink   (input valid, eased_value, time_clamped, output ready);
endinterface

// File: src/polynomial_easing_curve.sv
// ----------------------------------------------------------------------------
// polynomial_easing_curve
// quad / cubic / quart ease-in, ease-out and ease-in-out between two values
// ----------------------------------------------------------------------------
// channel   dir   handshake          payload
// req       in    valid / ready      func, elapsed
// rsp       out   valid / ready      eased_value, time_clamped
// cfg       in    cfg_we             cfg_index, cfg_wdata (duration, start, end)
//
// one word per cycle sustained while rsp takes its words; a taken word runs
// through in, the restoring divider (one quotient bit a stage), sel, pw1 .. pw3,
// crv, mul, rnd and out; reset clears all valid bits and loads duration 1,
// start 0, end 0; every stage moves together; the pipe holds only while rsp
// has a word that is not taken, so req.ready follows that single condition
// ----------------------------------------------------------------------------
module polynomial_easing_curve import pec_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
    pec_req_if.sink                    req,
    pec_rsp_if.source                  rsp
);

    // truncating q1.frac product, operands never exceed one
    function automatic logic [Q_WIDTH-1:0] qmul(input logic [Q_WIDTH-1:0] a,
                                                 input logic [Q_WIDTH-1:0] b);
        logic [2*Q_WIDTH-1:0] prod;
        prod = a * b;
        return prod[FRAC_BITS +: Q_WIDTH];
    endfunction

    // curve code to shape and polynomial order
    function automatic curve_sel_t decode_func(input logic [FUNC_WIDTH-1:0] code);
        curve_sel_t sel;
        sel.kind  = KIND_NONE;
        sel.order = ORDER_2;
        unique case (code) inside
            FUNC_QUAD_IN, FUNC_CUBIC_IN, FUNC_QUART_IN:          sel.kind = KIND_IN;
            FUNC_QUAD_OUT, FUNC_CUBIC_OUT, FUNC_QUART_OUT:       sel.kind = KIND_OUT;
            FUNC_QUAD_INOUT, FUNC_CUBIC_INOUT, FUNC_QUART_INOUT: sel.kind = KIND_INOUT;
            default:                                             sel.kind = KIND_NONE;
        endcase
        unique case (code) inside
            FUNC_CUBIC_IN, FUNC_CUBIC_OUT, FUNC_CUBIC_INOUT:     sel.order = ORDER_3;
            FUNC_QUART_IN, FUNC_QUART_OUT, FUNC_QUART_INOUT:     sel.order = ORDER_4;
            default:                                             sel.order = ORDER_2;
        endcase
        return sel;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    // duration is stored with zero already mapped to one tick
    logic [TIME_WIDTH-1:0]        duration_reg, duration_next;
    logic signed [VAL_WIDTH-1:0]  start_value_reg, start_value_next;
    logic signed [VAL_WIDTH-1:0]  end_value_reg, end_value_next;
    // end minus start, exact; read only deep in the pipe
    logic signed [DIFF_WIDTH-1:0] diff_reg, diff_next;

    always_comb
    begin
        duration_next    = duration_reg;
        start_value_next = start_value_reg;
        end_value_next   = end_value_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DURATION:
                begin
                    if (cfg_wdata[TIME_WIDTH-1:0] == '0)
                        duration_next = TIME_WIDTH'(1);
                    else
                        duration_next = cfg_wdata[TIME_WIDTH-1:0];
                end
                REG_START_VALUE: start_value_next = cfg_wdata[VAL_WIDTH-1:0];
                REG_END_VALUE:   end_value_next   = cfg_wdata[VAL_WIDTH-1:0];
                default: ;
            endcase
        end
        diff_next = DIFF_WIDTH'(end_value_reg) - DIFF_WIDTH'(start_value_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg    <= TIME_WIDTH'(1);
            start_value_reg <= '0;
            end_value_reg   <= '0;
            diff_reg        <= '0;
        end
        else
        begin
            duration_reg    <= duration_next;
            start_value_reg <= start_value_next;
            end_value_reg   <= end_value_next;
            diff_reg        <= diff_next;
        end
    end

    // ------------------------------------------------------------------
    // pipe advance: everything moves unless the result word is stuck
    // ------------------------------------------------------------------
    logic advance;
    assign advance   = !rsp.valid || rsp.ready;
    assign req.ready = advance;

    // ------------------------------------------------------------------
    // stage in: clamp the time and take the integer quotient bit
    // te <= duration, so that bit is set exactly when te equals duration
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    logic [FUNC_WIDTH-1:0] in_func_reg, in_func_next;
    logic                  in_clamp_reg, in_clamp_next;
    logic [TIME_WIDTH-1:0] in_rem_reg, in_rem_next;
    logic [Q_WIDTH-1:0]    in_quo_reg, in_quo_next;

    always_comb
    begin
        in_func_next  = req.func;
        in_clamp_next = req.elapsed > duration_reg;
        if (req.elapsed >= duration_reg)
        begin
            in_rem_next = '0;
            in_quo_next = Q_WIDTH'(1);
        end
        else
        begin
            in_rem_next = req.elapsed;
            in_quo_next = '0;
        end
    end

    // ------------------------------------------------------------------
    // divider: one fractional quotient bit per stage, remainder < duration
    // ------------------------------------------------------------------
    logic                  div_valid_reg [FRAC_BITS];
    logic [FUNC_WIDTH-1:0] div_func_reg  [FRAC_BITS];
    logic                  div_clamp_reg [FRAC_BITS];
    logic [TIME_WIDTH-1:0] div_rem_reg   [FRAC_BITS];
    logic [TIME_WIDTH-1:0] div_rem_next  [FRAC_BITS];
    logic [Q_WIDTH-1:0]    div_quo_reg   [FRAC_BITS];
    logic [Q_WIDTH-1:0]    div_quo_next  [FRAC_BITS];

    logic                  div_valid_src [FRAC_BITS];
    logic [FUNC_WIDTH-1:0] div_func_src  [FRAC_BITS];
    logic                  div_clamp_src [FRAC_BITS];
    logic [TIME_WIDTH-1:0] div_rem_src   [FRAC_BITS];
    logic [Q_WIDTH-1:0]    div_quo_src   [FRAC_BITS];
    logic [TIME_WIDTH:0]   div_shift     [FRAC_BITS];
    logic                  div_ge        [FRAC_BITS];

    assign div_valid_src[0] = in_valid_reg;
    assign div_func_src[0]  = in_func_reg;
    assign div_clamp_src[0] = in_clamp_reg;
    assign div_rem_src[0]   = in_rem_reg;
    assign div_quo_src[0]   = in_quo_reg;

    for (genvar g = 1; g < FRAC_BITS; g++)
    begin : g_div_link
        assign div_valid_src[g] = div_valid_reg[g-1];
        assign div_func_src[g]  = div_func_reg[g-1];
        assign div_clamp_src[g] = div_clamp_reg[g-1];
        assign div_rem_src[g]   = div_rem_reg[g-1];
        assign div_quo_src[g]   = div_quo_reg[g-1];
    end

    always_comb
    begin
        for (int i = 0; i < FRAC_BITS; i++)
        begin
            div_shift[i] = {div_rem_src[i], 1'b0};
            div_ge[i]    = div_shift[i] >= {1'b0, duration_reg};
            if (div_ge[i])
                div_rem_next[i] = TIME_WIDTH'(div_shift[i] - {1'b0, duration_reg});
            else
                div_rem_next[i] = div_shift[i][TIME_WIDTH-1:0];
            div_quo_next[i] = {div_quo_src[i][Q_WIDTH-2:0], div_ge[i]};
        end
    end

    // progress p, q1.frac in 0 .. one
    logic                  p_valid;
    logic [FUNC_WIDTH-1:0] p_func;
    logic                  p_clamp;
    logic [Q_WIDTH-1:0]    p_value;

    assign p_valid = div_valid_reg[FRAC_BITS-1];
    assign p_func  = div_func_reg[FRAC_BITS-1];
    assign p_clamp = div_clamp_reg[FRAC_BITS-1];
    assign p_value = div_quo_reg[FRAC_BITS-1];

    // ------------------------------------------------------------------
    // stage sel: decode the curve and form the power base
    //   in: p   out: one - p   in-out: 2 * min(p, one - p)
    // ------------------------------------------------------------------
    logic               sel_valid_reg;
    logic               sel_clamp_reg;
    curve_kind_t        sel_kind_reg, sel_kind_next;
    curve_order_t       sel_order_reg, sel_order_next;
    logic               sel_hi_reg, sel_hi_next;
    logic [Q_WIDTH-1:0] sel_x_reg, sel_x_next;
    curve_sel_t         sel_dec;
    logic [Q_WIDTH-1:0] sel_fold;

    always_comb
    begin
        sel_dec        = decode_func(p_func);
        sel_kind_next  = sel_dec.kind;
        sel_order_next = sel_dec.order;
        sel_hi_next    = p_value >= Q_HALF;
        sel_fold       = sel_hi_next ? (Q_ONE - p_value) : p_value;
        case (sel_dec.kind)
            KIND_IN:    sel_x_next = p_value;
            KIND_OUT:   sel_x_next = Q_ONE - p_value;
            KIND_INOUT: sel_x_next = {sel_fold[Q_WIDTH-2:0], 1'b0};
            default:    sel_x_next = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // power stages: square, then up to two more truncated products
    // ------------------------------------------------------------------
    logic               pw1_valid_reg, pw1_clamp_reg, pw1_hi_reg;
    curve_kind_t        pw1_kind_reg;
    curve_order_t       pw1_order_reg;
    logic [Q_WIDTH-1:0] pw1_x_reg, pw1_acc_reg, pw1_acc_next;

    logic               pw2_valid_reg, pw2_clamp_reg, pw2_hi_reg;
    curve_kind_t        pw2_kind_reg;
    curve_order_t       pw2_order_reg;
    logic [Q_WIDTH-1:0] pw2_x_reg, pw2_acc_reg, pw2_acc_next;

    logic               pw3_valid_reg, pw3_clamp_reg, pw3_hi_reg;
    curve_kind_t        pw3_kind_reg;
    logic [Q_WIDTH-1:0] pw3_acc_reg, pw3_acc_next;

    always_comb
    begin
        pw1_acc_next = qmul(sel_x_reg, sel_x_reg);
        if (pw1_order_reg == ORDER_2)
            pw2_acc_next = pw1_acc_reg;
        else
            pw2_acc_next = qmul(pw1_acc_reg, pw1_x_reg);
        if (pw2_order_reg == ORDER_4)
            pw3_acc_next = qmul(pw2_acc_reg, pw2_x_reg);
        else
            pw3_acc_next = pw2_acc_reg;
    end

    // ------------------------------------------------------------------
    // stage crv: shape the power into the curve value c in 0 .. one
    // ------------------------------------------------------------------
    logic               crv_valid_reg, crv_clamp_reg;
    logic [Q_WIDTH-1:0] crv_c_reg, crv_c_next;
    logic [Q_WIDTH-1:0] crv_half;

    always_comb
    begin
        crv_half = pw3_acc_reg >> 1;
        case (pw3_kind_reg)
            KIND_IN:    crv_c_next = pw3_acc_reg;
            KIND_OUT:   crv_c_next = Q_ONE - pw3_acc_reg;
            KIND_INOUT: crv_c_next = pw3_hi_reg ? (Q_ONE - crv_half) : crv_half;
            default:    crv_c_next = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stage mul: (end - start) * c, signed
    // ------------------------------------------------------------------
    logic                         mul_valid_reg, mul_clamp_reg;
    logic signed [PROD_WIDTH-1:0] mul_prod_reg, mul_prod_next;
    logic signed [Q_WIDTH:0]      mul_c;

    always_comb
    begin
        mul_c         = {1'b0, crv_c_reg};
        mul_prod_next = diff_reg * mul_c;
    end

    // ------------------------------------------------------------------
    // stage rnd: add one half and drop the fraction (floor)
    // ------------------------------------------------------------------
    logic                          rnd_valid_reg, rnd_clamp_reg;
    logic signed [SCALE_WIDTH-1:0] rnd_s_reg, rnd_s_next;
    logic signed [PROD_WIDTH-1:0]  rnd_sum;

    always_comb
    begin
        rnd_sum    = mul_prod_reg + ROUND_HALF;
        rnd_s_next = rnd_sum[PROD_WIDTH-1:FRAC_BITS];
    end

    // ------------------------------------------------------------------
    // output register: start + s, saturated to the value range
    // ------------------------------------------------------------------
    logic                          out_valid_reg;
    logic                          out_clamp_reg;
    logic signed [VAL_WIDTH-1:0]   out_value_reg, out_value_next;
    logic signed [SCALE_WIDTH-1:0] out_sum;

    always_comb
    begin
        out_sum = SCALE_WIDTH'(start_value_reg) + rnd_s_reg;
        if (out_sum > VAL_MAX)
            out_value_next = VAL_MAX[VAL_WIDTH-1:0];
        else if (out_sum < VAL_MIN)
            out_value_next = VAL_MIN[VAL_WIDTH-1:0];
        else
            out_value_next = out_sum[VAL_WIDTH-1:0];
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.eased_value  = out_value_reg;
    assign rsp.time_clamped = out_clamp_reg;

    // ------------------------------------------------------------------
    // valid bits, cleared by reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            for (int i = 0; i < FRAC_BITS; i++)
                div_valid_reg[i] <= 1'b0;
            sel_valid_reg <= 1'b0;
            pw1_valid_reg <= 1'b0;
            pw2_valid_reg <= 1'b0;
            pw3_valid_reg <= 1'b0;
            crv_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            rnd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg  <= req.valid;
            for (int i = 0; i < FRAC_BITS; i++)
                div_valid_reg[i] <= div_valid_src[i];
            sel_valid_reg <= p_valid;
            pw1_valid_reg <= sel_valid_reg;
            pw2_valid_reg <= pw1_valid_reg;
            pw3_valid_reg <= pw2_valid_reg;
            crv_valid_reg <= pw3_valid_reg;
            mul_valid_reg <= crv_valid_reg;
            rnd_valid_reg <= mul_valid_reg;
            out_valid_reg <= rnd_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // data registers, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_func_reg  <= in_func_next;
            in_clamp_reg <= in_clamp_next;
            in_rem_reg   <= in_rem_next;
            in_quo_reg   <= in_quo_next;

            for (int i = 0; i < FRAC_BITS; i++)
            begin
                div_func_reg[i]  <= div_func_src[i];
                div_clamp_reg[i] <= div_clamp_src[i];
                div_rem_reg[i]   <= div_rem_next[i];
                div_quo_reg[i]   <= div_quo_next[i];
            end

            sel_clamp_reg <= p_clamp;
            sel_kind_reg  <= sel_kind_next;
            sel_order_reg <= sel_order_next;
            sel_hi_reg    <= sel_hi_next;
            sel_x_reg     <= sel_x_next;

            pw1_clamp_reg <= sel_clamp_reg;
            pw1_kind_reg  <= sel_kind_reg;
            pw1_order_reg <= sel_order_reg;
            pw1_hi_reg    <= sel_hi_reg;
            pw1_x_reg     <= sel_x_reg;
            pw1_acc_reg   <= pw1_acc_next;

            pw2_clamp_reg <= pw1_clamp_reg;
            pw2_kind_reg  <= pw1_kind_reg;
            pw2_order_reg <= pw1_order_reg;
            pw2_hi_reg    <= pw1_hi_reg;
            pw2_x_reg     <= pw1_x_reg;
            pw2_acc_reg   <= pw2_acc_next;

            pw3_clamp_reg <= pw2_clamp_reg;
            pw3_kind_reg  <= pw2_kind_reg;
            pw3_hi_reg    <= pw2_hi_reg;
            pw3_acc_reg   <= pw3_acc_next;

            crv_clamp_reg <= pw3_clamp_reg;
            crv_c_reg     <= crv_c_next;

            mul_clamp_reg <= crv_clamp_reg;
            mul_prod_reg  <= mul_prod_next;

            rnd_clamp_reg <= mul_clamp_reg;
            rnd_s_reg     <= rnd_s_next;

            out_clamp_reg <= rnd_clamp_reg;
            out_value_reg <= out_value_next;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // remainder of the last divider stage always stays below the divisor
    a_div_rem_below_duration: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid |-> (div_rem_reg[FRAC_BITS-1] < duration_reg))
        else $error("divider remainder not below duration");

    // progress never exceeds one: integer bit set means zero fraction
    a_progress_max_one: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid && p_value[FRAC_BITS]) |-> (p_value[FRAC_BITS-1:0] == '0))
        else $error("progress above one");

    // power base stays within 0 .. one for every curve shape
    a_base_max_one: assert property (@(posedge clk) disable iff (!rst_n)
        sel_valid_reg |-> (sel_x_reg <= Q_ONE))
        else $error("power base above one");

    // curve value stays within 0 .. one
    a_curve_max_one: assert property (@(posedge clk) disable iff (!rst_n)
        crv_valid_reg |-> (crv_c_reg <= Q_ONE))
        else $error("curve value above one");

    // a held result word keeps the whole pipe frozen, no word enters; checked on the in and rnd valid bits
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> ($stable(in_valid_reg) && $stable(rnd_valid_reg)))
        else $error("pipe moved during output stall");

endmodule
